// File: hdl/bigram_simhash_32_defines.svh
// Assertion macros for the bigram simhash block.
`ifndef BIGRAM_SIMHASH_32_DEFINES_SVH
`define BIGRAM_SIMHASH_32_DEFINES_SVH

// Checked on every rising edge of clk, held off while rst is high.
`ifndef SYNTH
`define BS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bigram_simhash_32 assertion failed");
`else
`define BS_ASSERT(lbl, prop)
`endif

// Checked on every rising edge of clk, reset included.
`ifndef SYNTH
`define BS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bigram_simhash_32 assertion failed");
`else
`define BS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hdl/bs32_pkg.sv
`default_nettype none

package bs32_pkg;

  localparam int HASH_W     = 32;
  localparam int CHAR_W     = 32;
  localparam int DIST_W     = 6;
  localparam int VOTE_W     = 14;
  localparam int MAX_CHARS  = 4096;
  localparam int CHAR_CNT_W = $clog2(MAX_CHARS + 1);

  localparam logic signed [VOTE_W-1:0] VOTE_MAX = VOTE_W'(8191);
  localparam logic signed [VOTE_W-1:0] VOTE_MIN = VOTE_W'(-8192);

  localparam int MUL_IDX_W = 3;
  localparam logic [MUL_IDX_W-1:0] MUL_K1  = 3'd0;
  localparam logic [MUL_IDX_W-1:0] MUL_K2  = 3'd1;
  localparam logic [MUL_IDX_W-1:0] MUL_H1A = 3'd2;
  localparam logic [MUL_IDX_W-1:0] MUL_H1B = 3'd3;
  localparam logic [MUL_IDX_W-1:0] MUL_H2A = 3'd4;
  localparam logic [MUL_IDX_W-1:0] MUL_H2B = 3'd5;

  localparam logic [63:0] C_K1  = 64'h87c37b91114253d5;
  localparam logic [63:0] C_K2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] C_FM1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] C_FM2 = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic [CHAR_W-1:0] code_point;
    logic              last;
  } char_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] sim_hash;
    logic [DIST_W-1:0] distance_to_previous;
  } hash_item_t;

  function automatic logic [63:0] mul_const(input logic [MUL_IDX_W-1:0] idx);
    logic [63:0] k;
    case (idx)
      MUL_K1:           k = C_K1;
      MUL_K2:           k = C_K2;
      MUL_H1A, MUL_H2A: k = C_FM1;
      MUL_H1B, MUL_H2B: k = C_FM2;
      default:          k = C_K1;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bigram_simhash_32.sv
// A string's first character is only stored; each later character forms a bigram
// with its predecessor, hashed on the shared 32x32 multiplier plus 3 add/vote steps.
// A new character is accepted only in the idle state, after any bigram in flight.
// A last character then emits; the result sits in the output register until taken.
// Reset (rst, synchronous, active high) clears seed, votes, history and handshakes.
`default_nettype none
`include "bigram_simhash_32_defines.svh"

module bigram_simhash_32
  import bs32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_ready,
  input  wire char_item_t  char_item,
  output logic             hash_valid,
  input  wire logic        hash_ready,
  output hash_item_t       hash_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MIX_A,
    S_MIX_B,
    S_VOTE,
    S_EMIT
  } state_t;

  state_t                  state;
  logic [MUL_IDX_W-1:0]    mul_idx;
  logic [1:0]              phase;
  logic [31:0]             hash_seed;
  logic [CHAR_W-1:0]       prior_char;
  logic                    have_prior;
  logic [CHAR_CNT_W-1:0]   char_count;
  logic                    last_pending;
  logic [HASH_W-1:0]       previous_simhash;
  logic signed [VOTE_W-1:0] votes [HASH_W];
  logic [63:0]             x;
  logic [63:0]             h1;
  logic [63:0]             h2;
  logic [63:0]             acc;

  logic [63:0] seed64;
  logic [63:0] k_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] mul_res;
  logic [31:0] hv;
  logic [HASH_W-1:0] sim;
  logic [HASH_W-1:0] diff;
  logic        count_ok;
  logic        emit_go;
  logic        votes_zero;

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ {33'd0, v[63:33]};
  endfunction

  assign cfg_ready  = 1'b1;
  assign char_ready = (state == S_IDLE);
  assign seed64     = {32'd0, hash_seed};
  assign k_const    = mul_const(mul_idx);
  assign mul_a      = (phase == 2'd2) ? x[63:32] : x[31:0];
  assign mul_b      = (phase == 2'd1) ? k_const[63:32] : k_const[31:0];
  assign prod       = 64'(mul_a) * 64'(mul_b);
  assign mul_res    = {acc[63:32] + prod[31:0], acc[31:0]};
  assign hv         = h1[31:0] + x[31:0];
  assign count_ok   = char_count < CHAR_CNT_W'(MAX_CHARS);
  assign diff       = sim ^ previous_simhash;
  assign emit_go    = (state == S_EMIT) && (!hash_valid || hash_ready);

  always_comb begin
    votes_zero = 1'b1;
    for (int f = 0; f < HASH_W; f++) begin
      sim[f] = votes[f] > 0;
      if (votes[f] != '0) votes_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      mul_idx          <= '0;
      phase            <= '0;
      hash_seed        <= '0;
      prior_char       <= '0;
      have_prior       <= 1'b0;
      char_count       <= '0;
      last_pending     <= 1'b0;
      previous_simhash <= '0;
      hash_valid       <= 1'b0;
      for (int f = 0; f < HASH_W; f++) votes[f] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) hash_seed <= cfg_data;
      if (hash_valid && hash_ready && !emit_go) hash_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (char_valid) begin
            last_pending <= char_item.last;
            if (count_ok) begin
              prior_char <= char_item.code_point;
              have_prior <= 1'b1;
              char_count <= char_count + 1'b1;
            end
            if (count_ok && have_prior) begin
              x       <= {char_item.code_point, prior_char};
              mul_idx <= MUL_K1;
              phase   <= 2'd0;
              state   <= S_MUL;
            end else if (char_item.last) begin
              state <= S_EMIT;
            end
          end
        end
        S_MUL: begin
          case (phase)
            2'd0: begin
              acc   <= prod;
              phase <= 2'd1;
            end
            2'd1: begin
              acc[63:32] <= acc[63:32] + prod[31:0];
              phase      <= 2'd2;
            end
            default: begin
              phase   <= 2'd0;
              mul_idx <= (mul_idx == MUL_H2B) ? MUL_K1 : mul_idx + 1'b1;
              case (mul_idx)
                MUL_K1: x <= {mul_res[32:0], mul_res[63:33]};
                MUL_K2: begin
                  x     <= mul_res;
                  state <= S_MIX_A;
                end
                MUL_H1B: begin
                  h1 <= xs33(mul_res);
                  x  <= xs33(h2);
                end
                MUL_H2B: begin
                  x     <= xs33(mul_res);
                  state <= S_VOTE;
                end
                default: x <= xs33(mul_res);
              endcase
            end
          endcase
        end
        S_MIX_A: begin
          h1    <= (seed64 ^ x ^ 64'd8) + (seed64 ^ 64'd8);
          state <= S_MIX_B;
        end
        S_MIX_B: begin
          h2    <= (seed64 ^ 64'd8) + h1;
          x     <= xs33(h1);
          state <= S_MUL;
        end
        S_VOTE: begin
          for (int f = 0; f < HASH_W; f++) begin
            if (hv[f]) begin
              if (votes[f] < VOTE_MAX) votes[f] <= votes[f] + 1'b1;
            end else begin
              if (votes[f] > VOTE_MIN) votes[f] <= votes[f] - 1'b1;
            end
          end
          state <= last_pending ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            hash_item.sim_hash             <= sim;
            hash_item.distance_to_previous <= DIST_W'($countones(diff));
            hash_valid                     <= 1'b1;
            previous_simhash               <= sim;
            prior_char                     <= '0;
            have_prior                     <= 1'b0;
            char_count                     <= '0;
            for (int f = 0; f < HASH_W; f++) votes[f] <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BS_ASSERT(a_phase_range, phase != 2'd3)
  `BS_ASSERT(a_vote_after_last_mul,
    (state == S_VOTE) |-> ($past(state) == S_MUL && $past(mul_idx) == MUL_H2B))
  `BS_ASSERT(a_clear_after_emit,
    emit_go |=> (votes_zero && !have_prior && char_count == '0 && hash_valid))
  `BS_ASSERT(a_mul_idx_range, mul_idx <= MUL_H2B)
  `BS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !hash_valid))

endmodule

`default_nettype wire

// File: dv/tb_bigram_simhash_32.sv
`timescale 1ns / 100ps

module tb_bigram_simhash_32;
  import bs32_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 30;

  class simhash_tracker;
    logic [31:0] seed;
    logic [31:0] prior_cp;
    bit have_prior;
    logic signed [VOTE_W-1:0] votes [32];
    logic [31:0] prev_hash;
    int unsigned taken;
    hash_item_t expected_hashes [$];
    int unsigned mismatches;

    function new();
      seed = '0;
      prev_hash = '0;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (votes[f]) votes[f] = '0;
      prior_cp = '0;
      have_prior = 0;
      taken = 0;
    endfunction

    function logic [63:0] fmix64(logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * 64'hff51afd7ed558ccd;
      k = k ^ (k >> 33);
      k = k * 64'hc4ceb9fe1a85ec53;
      k = k ^ (k >> 33);
      return k;
    endfunction

    // MurmurHash3 x64_128 over an 8-byte key, low word of h1
    function logic [31:0] bigram_h1_lo(logic [31:0] a, logic [31:0] b);
      logic [63:0] h1;
      logic [63:0] h2;
      logic [63:0] k1;
      h1 = {32'h0, seed};
      h2 = h1;
      k1 = {b, a};
      k1 = k1 * 64'h87c37b91114253d5;
      k1 = {k1[32:0], k1[63:33]};
      k1 = k1 * 64'h4cf5ad432745937f;
      h1 = h1 ^ k1;
      h1 = h1 ^ 64'd8;
      h2 = h2 ^ 64'd8;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = fmix64(h1);
      h2 = fmix64(h2);
      h1 = h1 + h2;
      return h1[31:0];
    endfunction

    function void take_char(char_item_t c);
      logic [31:0] h;
      logic [31:0] sim;
      hash_item_t e;
      if (taken < MAX_CHARS) begin
        if (have_prior) begin
          h = bigram_h1_lo(prior_cp, c.code_point);
          for (int f = 0; f < 32; f++) begin
            if (h[f]) begin
              if (votes[f] < VOTE_MAX) votes[f] = votes[f] + 14'sd1;
            end else begin
              if (votes[f] > VOTE_MIN) votes[f] = votes[f] - 14'sd1;
            end
          end
        end
        prior_cp = c.code_point;
        have_prior = 1;
        taken++;
      end
      if (c.last) begin
        sim = '0;
        for (int f = 0; f < 32; f++) begin
          if (votes[f] > 0) sim[f] = 1'b1;
        end
        e.sim_hash = sim;
        e.distance_to_previous = DIST_W'($countones(sim ^ prev_hash));
        expected_hashes.push_back(e);
        prev_hash = sim;
        clear_string();
      end
    endfunction

    function void compare_hash(hash_item_t got);
      hash_item_t e;
      if (expected_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected hash transaction sim=%h dist=%0d",
                   $time, got.sim_hash, got.distance_to_previous);
        return;
      end
      e = expected_hashes.pop_front();
      if (got.sim_hash !== e.sim_hash ||
          got.distance_to_previous !== e.distance_to_previous) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp sim=%h dist=%0d got sim=%h dist=%0d", $time,
                   e.sim_hash, e.distance_to_previous,
                   got.sim_hash, got.distance_to_previous);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic char_valid;
  logic char_ready;
  char_item_t char_item;
  logic hash_valid;
  logic hash_ready = 1'b0;
  hash_item_t hash_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  bit no_stall = 0;
  int unsigned cycles = 0;
  simhash_tracker trk;

  bigram_simhash_32 DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_item  (hash_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    hash_ready <= no_stall || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (hash_valid && hash_ready) trk.compare_hash(hash_item);
      if (char_valid && char_ready) trk.take_char(char_item);
      if (cfg_valid && cfg_ready) trk.seed = cfg_data;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [31:0] cp, input logic lst);
    if (!no_stall) begin
      while ($urandom_range(0, 99) < 27) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
    end
    char_valid <= 1'b1;
    char_item <= '{code_point: cp, last: lst};
    do @(posedge clk); while (!char_ready);
  endtask

  // wait for every outstanding hash, then let the pipeline settle
  task automatic drain();
    char_valid <= 1'b0;
    do @(posedge clk); while (trk.expected_hashes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_cp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return $urandom_range(32'h20, 32'h7e);
    if (r < 85) return 32'h61 + $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_strings(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 80) len = $urandom_range(2, 8);
      else len = $urandom_range(9, 40);
      for (int i = 0; i < len; i++) send_char(pick_cp(), i == len - 1);
      sent += len;
      if ($urandom_range(0, 99) < 4) drain();
    end
  endtask

  initial begin
    trk = new();
    rst = 1'b1;
    char_valid = 1'b0;
    char_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, seed zero
    write_seed(32'h0000_0000);
    send_char(32'h0000_0000, 1'b1);
    send_char(32'hffff_ffff, 1'b1);
    send_char(32'h0000_0000, 1'b0);
    send_char(32'hffff_ffff, 1'b1);
    send_char(32'hffff_ffff, 1'b0);
    send_char(32'h0000_0000, 1'b1);
    send_char(32'hffff_ffff, 1'b0);
    send_char(32'h0000_0000, 1'b1);
    send_char(32'h0000_0001, 1'b0);
    send_char(32'h8000_0000, 1'b0);
    send_char(32'h7fff_ffff, 1'b1);
    send_char(32'h0000_0005, 1'b1);
    drain();

    // directed, all-ones seed
    write_seed(32'hffff_ffff);
    send_char(32'h0000_0000, 1'b0);
    send_char(32'hffff_ffff, 1'b1);
    send_char(32'h0000_0041, 1'b0);
    send_char(32'h0000_0042, 1'b0);
    send_char(32'h0000_0043, 1'b1);
    send_char(32'h0000_0043, 1'b1);
    drain();

    // string past the character limit, last flag on an ignored character
    write_seed($urandom);
    for (int i = 0; i < MAX_CHARS + 4; i++) send_char($urandom, i == MAX_CHARS + 3);
    send_char(32'h0000_0061, 1'b0);
    send_char(32'h0000_0062, 1'b1);
    drain();

    write_seed($urandom);
    random_strings(450);
    drain();

    no_stall = 1;
    write_seed(32'hffff_ffff);
    random_strings(400);
    drain();
    no_stall = 0;

    write_seed(32'h0000_0000);
    random_strings(400);
    drain();

    write_seed($urandom);
    random_strings(450);
    drain();

    repeat (40) @(posedge clk);
    if (trk.mismatches == 0 && trk.expected_hashes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/bs32_pkg.sv
hdl/bigram_simhash_32.sv
dv/tb_bigram_simhash_32.sv
